// File: design/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the same cycle.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

// File: design/strc_pkg.sv
// Package for the stepper ramp controller: widths, opcodes, modes, commands.
// Depends on nothing.
package strc_pkg;
    localparam int POSITION_WIDTH_DEF = 32;
    localparam int DELAY_WIDTH_DEF    = 20;
    localparam int RAMP_WIDTH_DEF     = 16;
    localparam int CFG_DATA_WIDTH     = 20;
    localparam int SPEED_WIDTH        = 21;
    localparam int STEPS_WIDTH        = 32;
    localparam int DIV_NUM_WIDTH      = 52;
    localparam int DIV_CNT_WIDTH      = 6;

    localparam logic [1:0] CFG_MIN_DELAY = 2'd0;
    localparam logic [1:0] CFG_MAX_DELAY = 2'd1;
    localparam logic [1:0] CFG_RAMP      = 2'd2;
    localparam logic [1:0] CFG_LIMITS    = 2'd3;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_MOVE_R = 3'd1;
    localparam logic [2:0] OP_MOVE_A = 3'd2;
    localparam logic [2:0] OP_RUN    = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;
    localparam logic [2:0] OP_ZERO   = 3'd5;
    localparam logic [2:0] OP_ENABLE = 3'd6;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_ACCEL = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;
    localparam logic [1:0] MODE_DECEL = 2'd3;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // latch the accepted item
        logic exec;      // apply item; for a tick, apply up to the period phase
        logic div_start; // start the shared divider
        logic finish;    // write the divider quotient back (run / ramp step)
        logic out_load;  // capture result into the output register
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic need_div;  // the item needs a division
        logic div_done;
    } t_status;
endpackage

// File: design/strc_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on strc_pkg.
module strc_divider
    import strc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIV_NUM_WIDTH-1:0] i_num,
    input  logic [STEPS_WIDTH-1:0]   i_den,
    output logic                     o_done,
    output logic [DIV_NUM_WIDTH-1:0] o_quot
);
    logic [DIV_NUM_WIDTH-1:0] r_q, n_q;
    logic [STEPS_WIDTH:0]     r_rem, n_rem;
    logic [STEPS_WIDTH-1:0]   r_den;
    logic [DIV_CNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                     r_busy, n_busy, r_done, n_done;
    logic [STEPS_WIDTH:0]     w_try;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_try = {r_rem[STEPS_WIDTH-1:0], r_q[DIV_NUM_WIDTH-1]};
        if (i_start) begin
            n_q = i_num; n_rem = '0; n_cnt = DIV_CNT_WIDTH'(DIV_NUM_WIDTH - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // shift one numerator bit in, subtract if it fits
            if (w_try >= {1'b0, r_den}) begin
                n_rem = w_try - {1'b0, r_den};
                n_q   = {r_q[DIV_NUM_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = w_try;
                n_q   = {r_q[DIV_NUM_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: design/strc_datapath.sv
// Datapath: registers, motion state, position, ramp arithmetic and divider.
// Depends on strc_pkg and strc_divider.
module strc_datapath
    import strc_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int DELAY_WIDTH    = DELAY_WIDTH_DEF,
    parameter int RAMP_WIDTH     = RAMP_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0]     i_cfg_data,
    input  logic [2:0]                    i_opcode,
    input  logic [STEPS_WIDTH-1:0]        i_step_count,
    input  logic                          i_move_dir,
    input  logic [POSITION_WIDTH-1:0]     i_goal_position,
    input  logic signed [SPEED_WIDTH-1:0] i_speed_sps,
    input  logic                          i_flag,
    input  logic                          i_cw_limit_hit,
    input  logic                          i_ccw_limit_hit,
    output logic                          o_step_pin,
    output logic                          o_dir_pin,
    output logic                          o_enable_n,
    output logic [1:0]                    o_motion_state,
    output logic [POSITION_WIDTH-1:0]     o_position_now
);
    localparam int DW = DELAY_WIDTH;
    localparam int RW = RAMP_WIDTH;
    localparam int PW = POSITION_WIDTH;

    // configuration
    logic [DW-1:0] r_min, r_max;
    logic [RW-1:0] r_ramp;
    logic          r_lim_en;
    // latched item
    logic [2:0]              r_op;
    logic [STEPS_WIDTH-1:0]  r_steps;
    logic                    r_mdir, r_flag, r_cwl, r_ccwl;
    logic [PW-1:0]           r_goal;
    logic [SPEED_WIDTH-1:0]  r_speed;
    // motion state
    logic [1:0]    r_mode;
    logic          r_dir, r_pulse, r_off;
    logic [PW-1:0] r_pos, r_tgt;
    logic [DW-1:0] r_period;
    logic [31:0]   r_elapsed;
    logic [RW-1:0] r_rcnt;
    // pending ramp step, finished after the divide
    logic          r_pend, r_pend_sub, r_pend_clmin;
    logic [DW-1:0] r_pend_base;
    logic [DIV_NUM_WIDTH-1:0] r_num;
    logic [STEPS_WIDTH-1:0]   r_den;
    // result register
    logic          r_o_pulse, r_o_dir, r_o_off;
    logic [1:0]    r_o_mode;
    logic [PW-1:0] r_o_pos;

    logic          w_div_done;
    logic [DIV_NUM_WIDTH-1:0] w_quot;

    strc_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(r_num), .i_den(r_den), .o_done(w_div_done), .o_quot(w_quot)
    );

    // swapped-delay handling
    logic          w_ge;
    logic [DW-1:0] w_span;
    assign w_ge   = (r_max >= r_min);
    assign w_span = w_ge ? (r_max - r_min) : (r_min - r_max);

    logic [20:0] w_mag;
    assign w_mag = r_speed[20] ? (21'd0 - r_speed) : r_speed;

    // execution phase next-state
    logic [1:0]    n_mode;
    logic          n_dir, n_pulse, n_off, n_pend, n_pend_sub, n_pend_clmin;
    logic [PW-1:0] n_pos, n_tgt, w_rel;
    logic [DW-1:0] n_period, n_pend_base;
    logic [31:0]   n_elapsed;
    logic [RW-1:0] n_rcnt, w_rc1;
    logic [DIV_NUM_WIDTH-1:0] n_num;
    logic [STEPS_WIDTH-1:0]   n_den;
    logic [PW-1:0] w_pstep, w_remain;
    logic [PW:0]   w_ramp_x;
    logic [STEPS_WIDTH-1:0] w_msteps;
    logic          w_mdir;

    assign w_ramp_x = (PW+1)'(r_ramp);

    always_comb begin
        n_mode = r_mode; n_dir = r_dir; n_pulse = r_pulse; n_off = r_off;
        n_pos = r_pos; n_tgt = r_tgt; n_period = r_period; n_elapsed = r_elapsed;
        n_rcnt = r_rcnt; n_pend = 1'b0; n_pend_sub = r_pend_sub;
        n_pend_clmin = r_pend_clmin; n_pend_base = r_pend_base;
        n_num = r_num; n_den = r_den;
        w_msteps = r_steps; w_mdir = r_mdir; w_rel = '0;
        w_pstep = r_pos; w_remain = '0; w_rc1 = r_rcnt + 1'b1;
        unique case (r_op)
            OP_TICK: begin
                if (r_elapsed != 32'hFFFF_FFFF) n_elapsed = r_elapsed + 1'b1;
                if (r_mode != MODE_IDLE && n_elapsed >= 32'(r_period >> 1)) begin
                    if (r_lim_en && (r_dir ? r_ccwl : r_cwl)) begin
                        n_mode = MODE_IDLE;
                        if (r_dir) begin n_pos = '0; n_tgt = '0; end
                    end else begin
                        n_elapsed = '0;
                        if (!r_pulse) begin
                            n_pulse = 1'b1;
                        end else begin
                            n_pulse = 1'b0;
                            w_pstep = r_dir ? (r_pos - 1'b1) : (r_pos + 1'b1);
                            n_pos = w_pstep;
                            w_remain = r_dir ? (w_pstep - r_tgt) : (r_tgt - w_pstep);
                            if (r_dir ? (w_pstep <= r_tgt) : (w_pstep >= r_tgt)) begin
                                n_mode = MODE_IDLE;
                            end else if (r_mode == MODE_ACCEL) begin
                                n_rcnt = w_rc1;
                                if (w_rc1 < r_ramp) begin
                                    n_pend = 1'b1;
                                    n_pend_base = r_max; n_pend_sub = w_ge;
                                    n_pend_clmin = 1'b1;
                                    n_num = DIV_NUM_WIDTH'(w_span) * DIV_NUM_WIDTH'(w_rc1);
                                    n_den = STEPS_WIDTH'(r_ramp);
                                    if ((PW+1)'(w_remain) <= w_ramp_x) begin
                                        n_mode = MODE_DECEL; n_rcnt = '0;
                                    end
                                end else begin
                                    n_period = r_min; n_rcnt = '0;
                                    n_mode = ((PW+1)'(w_remain) <= w_ramp_x) ?
                                             MODE_DECEL : MODE_RUN;
                                end
                            end else if (r_mode == MODE_RUN) begin
                                n_period = r_min;
                                if ((PW+1)'(w_remain) <= w_ramp_x) n_mode = MODE_DECEL;
                            end else begin
                                if (w_remain != '0 && r_ramp != '0) begin
                                    n_pend = 1'b1;
                                    n_pend_base = r_min; n_pend_sub = !w_ge;
                                    n_pend_clmin = 1'b0;
                                    n_num = DIV_NUM_WIDTH'(w_span) *
                                        ((w_ramp_x > (PW+1)'(w_remain)) ?
                                         DIV_NUM_WIDTH'(w_ramp_x - (PW+1)'(w_remain)) :
                                         DIV_NUM_WIDTH'(0));
                                    n_den = STEPS_WIDTH'(r_ramp);
                                end else begin
                                    n_period = r_max;
                                end
                            end
                        end
                    end
                end
            end
            OP_MOVE_R, OP_MOVE_A: begin
                if (r_op == OP_MOVE_A) begin
                    if (r_goal > r_pos) begin
                        w_rel = r_goal - r_pos; w_mdir = 1'b0;
                    end else begin
                        w_rel = r_pos - r_goal; w_mdir = 1'b1;
                    end
                    w_msteps = STEPS_WIDTH'(w_rel);
                end
                n_dir = w_mdir;
                n_tgt = w_mdir ? (r_pos - PW'(w_msteps)) : (r_pos + PW'(w_msteps));
                n_period = r_max;
                n_mode = (r_ramp != '0 && {1'b0, w_msteps} > ({1'b0, 32'(r_ramp)} << 1))
                         ? MODE_ACCEL : MODE_RUN;
                n_rcnt = '0; n_pulse = 1'b0; n_off = 1'b0;
            end
            OP_RUN: begin
                if (r_speed == '0) begin
                    n_mode = MODE_IDLE; n_tgt = r_pos;
                end else begin
                    n_dir = r_speed[20];
                    n_tgt = r_speed[20] ? '0 : '1;
                    n_mode = MODE_RUN; n_pulse = 1'b0; n_off = 1'b0;
                    n_pend = 1'b1; n_pend_base = '0;
                    n_pend_sub = 1'b0; n_pend_clmin = 1'b0;
                    n_num = DIV_NUM_WIDTH'(1000000);
                    n_den = STEPS_WIDTH'(w_mag);
                end
            end
            OP_STOP: begin
                if (r_flag) begin
                    n_mode = MODE_IDLE; n_tgt = r_pos;
                end else if (r_mode != MODE_IDLE) begin
                    n_mode = MODE_DECEL;
                    n_tgt = r_dir ? (r_pos - PW'(r_ramp)) : (r_pos + PW'(r_ramp));
                end
            end
            OP_ZERO: begin n_pos = '0; n_tgt = '0; end
            OP_ENABLE: begin
                if (r_flag) n_off = 1'b0;
                else begin n_off = 1'b1; n_mode = MODE_IDLE; end
            end
            default: ;
        endcase
    end

    // finish a ramp or run step from the quotient
    logic [DIV_NUM_WIDTH:0] w_fin;
    logic [DW-1:0]          w_fin_p;
    always_comb begin
        if (r_op == OP_RUN) begin
            w_fin = {1'b0, w_quot};
        end else if (r_pend_sub) begin
            w_fin = (DIV_NUM_WIDTH+1)'(r_pend_base) - {1'b0, w_quot};
        end else begin
            w_fin = (DIV_NUM_WIDTH+1)'(r_pend_base) + {1'b0, w_quot};
        end
        w_fin_p = DW'(w_fin);
        if (r_op != OP_RUN) begin
            if (r_pend_clmin) begin
                if (w_fin[31:0] < 32'(r_min)) w_fin_p = r_min;
            end else begin
                if (w_fin[31:0] > 32'(r_max)) w_fin_p = r_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= DW'(500); r_max <= DW'(2000); r_ramp <= RW'(100); r_lim_en <= 1'b0;
            r_mode <= MODE_IDLE; r_dir <= 1'b0; r_pos <= '0; r_tgt <= '0;
            r_period <= DW'(1000); r_elapsed <= '0; r_pulse <= 1'b0;
            r_rcnt <= '0; r_off <= 1'b1; r_pend <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_DELAY: r_min <= DW'(i_cfg_data);
                    CFG_MAX_DELAY: r_max <= DW'(i_cfg_data);
                    CFG_RAMP:      r_ramp <= RW'(i_cfg_data);
                    CFG_LIMITS:    r_lim_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                r_mode <= n_mode; r_dir <= n_dir; r_pulse <= n_pulse; r_off <= n_off;
                r_pos <= n_pos; r_tgt <= n_tgt; r_period <= n_period;
                r_elapsed <= n_elapsed; r_rcnt <= n_rcnt; r_pend <= n_pend;
            end
            if (i_cmd.finish && r_pend) begin
                r_period <= w_fin_p; r_pend <= 1'b0;
            end
        end
        if (i_cmd.exec) begin
            r_pend_base <= n_pend_base; r_pend_sub <= n_pend_sub;
            r_pend_clmin <= n_pend_clmin; r_num <= n_num; r_den <= n_den;
        end
        if (i_cmd.load) begin
            r_op <= i_opcode; r_steps <= i_step_count; r_mdir <= i_move_dir;
            r_goal <= i_goal_position; r_speed <= i_speed_sps; r_flag <= i_flag;
            r_cwl <= i_cw_limit_hit; r_ccwl <= i_ccw_limit_hit;
        end
        if (i_cmd.out_load) begin
            r_o_pulse <= r_pulse; r_o_dir <= r_dir; r_o_off <= r_off;
            r_o_mode <= r_mode; r_o_pos <= r_pos;
        end
    end

    assign o_status.need_div = r_pend;
    assign o_status.div_done = w_div_done;
    assign o_step_pin     = r_o_pulse;
    assign o_dir_pin      = r_o_dir;
    assign o_enable_n     = r_o_off;
    assign o_motion_state = r_o_mode;
    assign o_position_now = r_o_pos;
endmodule

// File: design/strc_ctrl.sv
// Controller state machine sequencing load, execute, divide and output.
// Depends on strc_pkg.
module strc_ctrl
    import strc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_EXEC = 6'b000010, S_CHK  = 6'b000100,
        S_DIV  = 6'b001000, S_FIN  = 6'b010000, S_OUT  = 6'b100000
    } t_state;
    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   w_take;

    // Accept a new item whenever idle; S_OUT waits for the output register.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: if (w_take) begin o_cmd.load = 1'b1; n_state = S_EXEC; end
            S_EXEC: begin o_cmd.exec = 1'b1; n_state = S_CHK; end
            S_CHK: begin
                if (i_status.need_div) begin
                    o_cmd.div_start = 1'b1; n_state = S_DIV;
                end else n_state = S_OUT;
            end
            S_DIV: if (i_status.div_done) n_state = S_FIN;
            S_FIN: begin o_cmd.finish = 1'b1; n_state = S_OUT; end
            S_OUT: begin
                // output register is free: item enters only when it is
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1; n_ovalid = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_ovalid <= n_ovalid;
        end
    end
    assign o_out_valid = r_ovalid;
endmodule

// File: design/stepper_trapezoid_ramp_controller_unit.sv
// Top level of the stepper trapezoid ramp controller.
// Depends on strc_pkg, strc_ctrl, strc_datapath.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | i_in_valid/o_in_ready  | opcode, step_count, ..., limit levels
//  out     | o_out_valid/i_out_ready| step_pin, dir_pin, enable_n, state, pos
//  cfg     | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// Steps: an item without a divide passes load, execute, check and output; a
// ramp or run step that divides also runs the 52-bit bit-serial divider.
// Reset: synchronous, active low; min/max delay, ramp and limit enable return to 500/2000/100/0.
// The output register holds a result while the next item is accepted;
// a stalled output holds the next result in the controller's output state.
module stepper_trapezoid_ramp_controller_unit
    import strc_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int DELAY_WIDTH    = DELAY_WIDTH_DEF,
    parameter int RAMP_WIDTH     = RAMP_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_opcode,
    input  logic [STEPS_WIDTH-1:0]        i_step_count,
    input  logic                          i_move_dir,
    input  logic [POSITION_WIDTH-1:0]     i_goal_position,
    input  logic signed [SPEED_WIDTH-1:0] i_speed_sps,
    input  logic                          i_flag,
    input  logic                          i_cw_limit_hit,
    input  logic                          i_ccw_limit_hit,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_step_pin,
    output logic                          o_dir_pin,
    output logic                          o_enable_n,
    output logic [1:0]                    o_motion_state,
    output logic [POSITION_WIDTH-1:0]     o_position_now
);
    t_cmd    w_cmd;
    t_status w_status;

    strc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready), .o_cmd(w_cmd), .i_status(w_status)
    );

    strc_datapath #(
        .POSITION_WIDTH(POSITION_WIDTH), .DELAY_WIDTH(DELAY_WIDTH),
        .RAMP_WIDTH(RAMP_WIDTH)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_opcode(i_opcode), .i_step_count(i_step_count), .i_move_dir(i_move_dir),
        .i_goal_position(i_goal_position), .i_speed_sps(i_speed_sps),
        .i_flag(i_flag), .i_cw_limit_hit(i_cw_limit_hit),
        .i_ccw_limit_hit(i_ccw_limit_hit), .o_step_pin(o_step_pin),
        .o_dir_pin(o_dir_pin), .o_enable_n(o_enable_n),
        .o_motion_state(o_motion_state), .o_position_now(o_position_now)
    );
endmodule

// File: design/strc_checker.sv
// Port-level checker for the stepper ramp controller, bound to the top.
// Depends on assert_macros.svh and strc_pkg.
`include "assert_macros.svh"
module strc_checker
    import strc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_enable_n,
    input logic [1:0] o_motion_state
);
    `CHK_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "busy")
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "dropped")
    // A disabled driver always reports an idle axis.
    `CHK_SAME(a_off_idle, i_clk, i_rst_n, o_out_valid && o_enable_n, o_motion_state == MODE_IDLE, "off")
endmodule

bind stepper_trapezoid_ramp_controller_unit strc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_enable_n(o_enable_n), .o_motion_state(o_motion_state)
);
